// ----- rtl/core/rgpg_pkg.sv -----
// Shared types and constants of the radial gradient pixel generator.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package rgpg_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int INDEX_W      = 8;
  localparam int COLOR_W      = 32;
  localparam int DIM_CFG_W    = 13;
  localparam int SCALE_W      = 24;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int MID_DEPTH    = 4;
  localparam int OUT_DEPTH    = 8;
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int RESULT_W     = COLOR_W + 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_X_SCALE      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_SCALE      = 8'd3;

  localparam logic [DIM_CFG_W-1:0] RESET_DIM   = 13'd256;
  localparam logic [SCALE_W-1:0]   RESET_SCALE = 24'd92681;

  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_PIXEL       = 1'b1;

  typedef struct packed {
    logic cmd;
    logic eor;
    logic eof;
  } rgpg_ctl_t;

  localparam int CTL_W = $bits(rgpg_ctl_t);

endpackage

`default_nettype wire

// ----- rtl/core/rgpg_fifo.sv -----
// Small register queue with count, full and empty.
// Depends on nothing outside this file.
`default_nettype none

module rgpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                rdata,
  output logic                            full,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/core/rgpg_front.sv -----
// Front end: accepts commands, walks the raster and computes pixel distances.
// Depends on rgpg_pkg.
`default_nettype none

module rgpg_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_push,
  input  wire logic                                 in_cmd,
  input  wire logic [rgpg_pkg::INDEX_W-1:0]         in_entry_index,
  input  wire logic [rgpg_pkg::COLOR_W-1:0]         in_entry_color,
  input  wire logic [rgpg_pkg::DIM_CFG_W-1:0]       image_width,
  input  wire logic [rgpg_pkg::DIM_CFG_W-1:0]       image_height,
  input  wire logic                                 geo_restart,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output rgpg_pkg::rgpg_ctl_t                       q_ctl,
  output logic [rgpg_pkg::INDEX_W-1:0]              q_entry_index,
  output logic [rgpg_pkg::COLOR_W-1:0]              q_entry_color,
  output logic [$clog2(MAX_DIMENSION)-1:0]          q_dx,
  output logic [$clog2(MAX_DIMENSION)-1:0]          q_dy
);

  localparam int PW = $clog2(MAX_DIMENSION);
  localparam int DW = PW + 1;
  localparam int CW = (DW > rgpg_pkg::DIM_CFG_W) ? DW : rgpg_pkg::DIM_CFG_W;

  function automatic logic [DW-1:0] clamp_dim(input logic [rgpg_pkg::DIM_CFG_W-1:0] v);
    logic [CW-1:0] ve;
    logic [DW-1:0] res;
    ve = CW'(v);
    if (ve < CW'(2)) begin
      res = DW'(2);
    end else if (ve > CW'(MAX_DIMENSION)) begin
      res = DW'(MAX_DIMENSION);
    end else begin
      res = DW'(ve);
    end
    return res;
  endfunction

  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] row_r, row_nxt;
  logic [DW-1:0] w, h, hx, hy, colx, rowx, mirror, dx_full, dy_full;
  logic          eor, eof, accept;

  assign w      = clamp_dim(image_width);
  assign h      = clamp_dim(image_height);
  assign hx     = w >> 1;
  assign hy     = h >> 1;
  assign colx   = {1'b0, col_r};
  assign rowx   = {1'b0, row_r};
  assign accept = in_push & ~q_full;

  always_comb begin
    dx_full = (colx >= hx) ? (colx - hx) : (hx - colx);
    mirror  = h - DW'(1) - rowx;
    if (rowx < mirror) begin
      mirror = rowx;
    end
    dy_full = hy - mirror;
  end

  assign eor = (colx == w - DW'(1));
  assign eof = eor & (rowx == h - DW'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geo_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept && in_cmd == rgpg_pkg::CMD_PIXEL) begin
      if (eor) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + PW'(1);
      end else begin
        col_nxt = col_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign q_push        = accept;
  assign q_ctl.cmd     = in_cmd;
  assign q_ctl.eor     = eor;
  assign q_ctl.eof     = eof;
  assign q_entry_index = in_entry_index;
  assign q_entry_color = in_entry_color;
  assign q_dx          = dx_full[PW-1:0];
  assign q_dy          = dy_full[PW-1:0];

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    colx < w)
    else $error("column position outside the row");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    rowx < h)
    else $error("row position outside the frame");

endmodule

`default_nettype wire

// ----- rtl/core/rgpg_back.sv -----
// Back end: scales distances, takes the square root, writes and reads the color table.
// Depends on rgpg_pkg; pushes results into the output queue under credit.
`default_nettype none

module rgpg_back #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [rgpg_pkg::SCALE_W-1:0]         x_scale,
  input  wire logic [rgpg_pkg::SCALE_W-1:0]         y_scale,
  input  wire logic                                 q_empty,
  input  wire rgpg_pkg::rgpg_ctl_t                  q_ctl,
  input  wire logic [rgpg_pkg::INDEX_W-1:0]         q_entry_index,
  input  wire logic [rgpg_pkg::COLOR_W-1:0]         q_entry_color,
  input  wire logic [$clog2(MAX_DIMENSION)-1:0]     q_dx,
  input  wire logic [$clog2(MAX_DIMENSION)-1:0]     q_dy,
  output logic                                      q_pop,
  input  wire logic [rgpg_pkg::OUT_CNT_W-1:0]       out_count,
  output logic                                      out_push,
  output logic [rgpg_pkg::RESULT_W-1:0]             out_data
);

  localparam int PW  = $clog2(MAX_DIMENSION);
  localparam int PRW = PW + rgpg_pkg::SCALE_W;
  localparam int IW  = rgpg_pkg::INDEX_W;
  localparam int CRW = rgpg_pkg::OUT_CNT_W + 1;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] pair);
    logic [10:0] r;
    logic [10:0] trial;
    sqrt_t       o;
    r     = {s.rem, pair};
    trial = {1'b0, s.root, 2'b01};
    if (r >= trial) begin
      r      = r - trial;
      o.root = {s.root[6:0], 1'b1};
    end else begin
      o.root = {s.root[6:0], 1'b0};
    end
    o.rem = r[8:0];
    return o;
  endfunction

  logic                    s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  rgpg_pkg::rgpg_ctl_t     s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r;
  logic [IW-1:0]           s1_addr_r, s2_addr_r, s3_addr_r, s4_addr_r;
  logic [rgpg_pkg::COLOR_W-1:0] s1_color_r, s2_color_r, s3_color_r, s4_color_r;
  logic [7:0]              s1_sx_r, s1_sy_r;
  logic                    s1_sat_r, s2_sat_r, s3_sat_r;
  logic [15:0]             s2_sum_r;
  sqrt_t                   s3_sq_r;
  logic [7:0]              s3_low_r;
  logic [rgpg_pkg::COLOR_W-1:0] s5_rd_r;
  logic [rgpg_pkg::COLOR_W-1:0] table_mem [rgpg_pkg::TABLE_DEPTH];

  logic [PRW-1:0]          px, py;
  logic                    sat1;
  logic [16:0]             sum;
  sqrt_t                   sq_hi, sq_lo;
  logic [2:0]              inflight;
  logic [CRW-1:0]          credit_used;

  assign inflight = {2'b00, s1_v_r} + {2'b00, s2_v_r} + {2'b00, s3_v_r}
                  + {2'b00, s4_v_r} + {2'b00, s5_v_r};
  assign credit_used = CRW'(out_count) + CRW'(inflight);
  assign q_pop = ~q_empty & (credit_used < CRW'(rgpg_pkg::OUT_DEPTH));

  assign px   = PRW'(q_dx) * PRW'(x_scale);
  assign py   = PRW'(q_dy) * PRW'(y_scale);
  assign sat1 = (|px[PRW-1:24]) | (|py[PRW-1:24]);
  assign sum  = {1'b0, 16'(s1_sx_r) * 16'(s1_sx_r)} + {1'b0, 16'(s1_sy_r) * 16'(s1_sy_r)};

  always_comb begin
    sq_hi = '0;
    for (int i = 3; i >= 0; i--) begin
      sq_hi = sqrt_step(sq_hi, s2_sum_r[8 + 2*i +: 2]);
    end
    sq_lo = s3_sq_r;
    for (int i = 3; i >= 0; i--) begin
      sq_lo = sqrt_step(sq_lo, s3_low_r[2*i +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r & (s4_ctl_r.cmd == rgpg_pkg::CMD_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r   <= q_ctl;
    s1_addr_r  <= q_entry_index;
    s1_color_r <= q_entry_color;
    s1_sx_r    <= px[23:16];
    s1_sy_r    <= py[23:16];
    s1_sat_r   <= sat1;

    s2_ctl_r   <= s1_ctl_r;
    s2_addr_r  <= s1_addr_r;
    s2_color_r <= s1_color_r;
    s2_sum_r   <= sum[15:0];
    s2_sat_r   <= s1_sat_r | sum[16];

    s3_ctl_r   <= s2_ctl_r;
    s3_addr_r  <= s2_addr_r;
    s3_color_r <= s2_color_r;
    s3_sq_r    <= sq_hi;
    s3_low_r   <= s2_sum_r[7:0];
    s3_sat_r   <= s2_sat_r;

    s4_ctl_r   <= s3_ctl_r;
    s4_color_r <= s3_color_r;
    if (s3_ctl_r.cmd == rgpg_pkg::CMD_PIXEL) begin
      s4_addr_r <= s3_sat_r ? '1 : sq_lo.root;
    end else begin
      s4_addr_r <= s3_addr_r;
    end

    s5_ctl_r <= s4_ctl_r;
  end

  always_ff @(posedge clk) begin
    if (s4_v_r && s4_ctl_r.cmd == rgpg_pkg::CMD_TABLE_WRITE) begin
      table_mem[s4_addr_r] <= s4_color_r;
    end
    s5_rd_r <= table_mem[s4_addr_r];
  end

  assign out_push = s5_v_r;
  assign out_data = {s5_rd_r, s5_ctl_r.eor, s5_ctl_r.eof};

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= CRW'(rgpg_pkg::OUT_DEPTH))
    else $error("output credit overrun");

  a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && s4_ctl_r.cmd == rgpg_pkg::CMD_TABLE_WRITE |=> !s5_v_r)
    else $error("table write produced a result");

endmodule

`default_nettype wire

// ----- rtl/core/radial_gradient_pixel_generator_core.sv -----
// Radial gradient pixel generator: register file, front end, command queue,
// back end and result queue. Depends on rgpg_pkg, rgpg_fifo, rgpg_front, rgpg_back.
//
// Usage:
//   Load the 256-entry color table with cmd 0 items (entry_index, entry_color),
//   then push cmd 1 items; each emits the next raster pixel on the result side.
//   Input channel: in_push/in_full; one item transfers per cycle when not full.
//   Result channel: out_empty/out_pop; the oldest pixel is on out_* while
//   out_empty is low. Table writes produce no result.
//   Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
//   width, height, x scale or y scale; width/height writes restart the raster.
//   Throughput: one item per cycle both ways, sustained while out_pop is high.
//   Path: an input item passes the command queue, then five back-end stages
//   ending in the table read, then the result queue, to the result ports.
//   Reset: raster at row 0, column 0, registers at defaults; table undefined.
//   Receiver stall: the 8-entry result queue fills under credit, the back end
//   stops pulling, the 4-entry command queue fills and in_full rises.
`default_nettype none

module radial_gradient_pixel_generator_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_push,
  output logic                                      in_full,
  input  wire logic                                 in_cmd,
  input  wire logic [rgpg_pkg::INDEX_W-1:0]         in_entry_index,
  input  wire logic [rgpg_pkg::COLOR_W-1:0]         in_entry_color,
  output logic                                      out_empty,
  input  wire logic                                 out_pop,
  output logic [rgpg_pkg::COLOR_W-1:0]              out_pixel_color,
  output logic                                      out_end_of_row,
  output logic                                      out_end_of_frame,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rgpg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rgpg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int PW    = $clog2(MAX_DIMENSION);
  localparam int MID_W = rgpg_pkg::CTL_W + rgpg_pkg::INDEX_W + rgpg_pkg::COLOR_W + 2 * PW;

  logic [rgpg_pkg::DIM_CFG_W-1:0] width_r, width_nxt;
  logic [rgpg_pkg::DIM_CFG_W-1:0] height_r, height_nxt;
  logic [rgpg_pkg::SCALE_W-1:0]   x_scale_r, x_scale_nxt;
  logic [rgpg_pkg::SCALE_W-1:0]   y_scale_r, y_scale_nxt;
  logic                           cfg_wr, geo_restart;

  logic                           f_push;
  rgpg_pkg::rgpg_ctl_t            f_ctl;
  logic [rgpg_pkg::INDEX_W-1:0]   f_index;
  logic [rgpg_pkg::COLOR_W-1:0]   f_color;
  logic [PW-1:0]                  f_dx, f_dy;

  logic [MID_W-1:0]               mid_wdata, mid_rdata;
  logic                           mid_full, mid_empty, mid_pop;
  logic [$clog2(rgpg_pkg::MID_DEPTH+1)-1:0] mid_count;

  rgpg_pkg::rgpg_ctl_t            b_ctl;
  logic [rgpg_pkg::INDEX_W-1:0]   b_index;
  logic [rgpg_pkg::COLOR_W-1:0]   b_color;
  logic [PW-1:0]                  b_dx, b_dy;

  logic                           res_push, res_full;
  logic [rgpg_pkg::RESULT_W-1:0]  res_wdata, res_rdata;
  logic [rgpg_pkg::OUT_CNT_W-1:0] res_count;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid & cfg_ready;
  assign geo_restart = cfg_wr & ((cfg_index == rgpg_pkg::REG_IMAGE_WIDTH) ||
                                 (cfg_index == rgpg_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    x_scale_nxt = x_scale_r;
    y_scale_nxt = y_scale_r;
    if (cfg_wr) begin
      case (cfg_index)
        rgpg_pkg::REG_IMAGE_WIDTH:  width_nxt   = cfg_wdata[rgpg_pkg::DIM_CFG_W-1:0];
        rgpg_pkg::REG_IMAGE_HEIGHT: height_nxt  = cfg_wdata[rgpg_pkg::DIM_CFG_W-1:0];
        rgpg_pkg::REG_X_SCALE:      x_scale_nxt = cfg_wdata[rgpg_pkg::SCALE_W-1:0];
        rgpg_pkg::REG_Y_SCALE:      y_scale_nxt = cfg_wdata[rgpg_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rgpg_pkg::RESET_DIM;
      height_r  <= rgpg_pkg::RESET_DIM;
      x_scale_r <= rgpg_pkg::RESET_SCALE;
      y_scale_r <= rgpg_pkg::RESET_SCALE;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      x_scale_r <= x_scale_nxt;
      y_scale_r <= y_scale_nxt;
    end
  end

  rgpg_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .image_width    (width_r),
    .image_height   (height_r),
    .geo_restart    (geo_restart),
    .q_full         (mid_full),
    .q_push         (f_push),
    .q_ctl          (f_ctl),
    .q_entry_index  (f_index),
    .q_entry_color  (f_color),
    .q_dx           (f_dx),
    .q_dy           (f_dy)
  );

  assign in_full   = mid_full;
  assign mid_wdata = {f_ctl, f_index, f_color, f_dx, f_dy};

  rgpg_fifo #(
    .WIDTH(MID_W),
    .DEPTH(rgpg_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign {b_ctl, b_index, b_color, b_dx, b_dy} = mid_rdata;

  rgpg_back #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .x_scale       (x_scale_r),
    .y_scale       (y_scale_r),
    .q_empty       (mid_empty),
    .q_ctl         (b_ctl),
    .q_entry_index (b_index),
    .q_entry_color (b_color),
    .q_dx          (b_dx),
    .q_dy          (b_dy),
    .q_pop         (mid_pop),
    .out_count     (res_count),
    .out_push      (res_push),
    .out_data      (res_wdata)
  );

  rgpg_fifo #(
    .WIDTH(rgpg_pkg::RESULT_W),
    .DEPTH(rgpg_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (out_pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (out_empty),
    .count (res_count)
  );

  assign {out_pixel_color, out_end_of_row, out_end_of_frame} = res_rdata;

  a_mid_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_full |-> !mid_empty && (mid_count != '0) && !(res_push && res_full))
    else $error("queue status inconsistent");

endmodule

`default_nettype wire

// ----- verif/tb_radial_gradient_pixel_generator_core.sv -----
// Self-checking testbench for radial_gradient_pixel_generator_core: table loads, raster pixels
// and register settings, checked against an in-bench gradient predictor with random idling.
// Depends on rgpg_pkg and the core RTL.
module tb_radial_gradient_pixel_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned RANDOM_ITEMS  = 1600;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned REPORT_LIMIT  = 10;
  // Q16 scale that maps half a dimension onto radius 181, times two
  localparam int unsigned RIM_SCALE_NUM = 23_724_032;
  localparam logic [rgpg_pkg::CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 8'd4;
  localparam logic [rgpg_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 8'hFF;

  typedef struct packed {
    logic [rgpg_pkg::COLOR_W-1:0] color;
    logic                         eor;
    logic                         eof;
  } pixel_result_t;

  typedef enum logic [1:0] {STEP_CONFIG, STEP_TABLE, STEP_PIXEL, STEP_PIXEL_KNOWN} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [7:0]         addr;
    logic [31:0]        data;
    logic               eor;
    logic               eof;
  } directed_step_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_LONG_HOLD, RX_EVERY_THIRD} rx_pattern_t;

  logic                             clk;
  logic                             rst_n          = 1'b0;
  logic                             in_push        = 1'b0;
  logic                             in_full;
  logic                             in_cmd         = rgpg_pkg::CMD_TABLE_WRITE;
  logic [rgpg_pkg::INDEX_W-1:0]     in_entry_index = '0;
  logic [rgpg_pkg::COLOR_W-1:0]     in_entry_color = '0;
  logic                             out_empty;
  logic                             out_pop        = 1'b0;
  logic [rgpg_pkg::COLOR_W-1:0]     out_pixel_color;
  logic                             out_end_of_row;
  logic                             out_end_of_frame;
  logic                             cfg_valid      = 1'b0;
  logic                             cfg_ready;
  logic [rgpg_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [rgpg_pkg::CFG_DATA_W-1:0]  cfg_wdata      = '0;

  // Predictor state
  logic [rgpg_pkg::DIM_CFG_W-1:0] cfg_width_q  = rgpg_pkg::RESET_DIM;
  logic [rgpg_pkg::DIM_CFG_W-1:0] cfg_height_q = rgpg_pkg::RESET_DIM;
  logic [rgpg_pkg::SCALE_W-1:0]   x_scale_q    = rgpg_pkg::RESET_SCALE;
  logic [rgpg_pkg::SCALE_W-1:0]   y_scale_q    = rgpg_pkg::RESET_SCALE;
  logic [11:0]                    raster_row   = '0;
  logic [11:0]                    raster_col   = '0;
  logic [rgpg_pkg::COLOR_W-1:0]   palette [rgpg_pkg::TABLE_DEPTH];
  bit                             palette_loaded [rgpg_pkg::TABLE_DEPTH];

  pixel_result_t  expected_pixels[$];
  directed_step_t directed_steps[$];

  int unsigned fail_count       = 0;
  int unsigned pixels_seen      = 0;
  int unsigned rows_seen        = 0;
  int unsigned frames_seen      = 0;
  int unsigned table_writes     = 0;
  int unsigned settings_applied = 0;
  int unsigned burst_left       = 1;

  rx_pattern_t rx_pattern = RX_STREAM;
  int unsigned rx_left    = 0;
  int unsigned rx_hold    = 0;
  int unsigned rx_tick    = 0;

  radial_gradient_pixel_generator_core #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_entry_color  (in_entry_color),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_color (out_pixel_color),
    .out_end_of_row  (out_end_of_row),
    .out_end_of_frame(out_end_of_frame),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d pixels still outstanding", expected_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned clamp_dimension(logic [rgpg_pkg::DIM_CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  function automatic logic [7:0] gradient_index();
    int unsigned w, h, hx, hy, dx, dy, near_edge;
    longint unsigned sx, sy, radius_sq, root, trial;
    w  = clamp_dimension(cfg_width_q);
    h  = clamp_dimension(cfg_height_q);
    hx = w / 2;
    hy = h / 2;
    dx = (raster_col >= hx) ? raster_col - hx : hx - raster_col;
    near_edge = (raster_row < h - 1 - raster_row) ? raster_row : h - 1 - raster_row;
    dy = hy - near_edge;
    sx = dx;
    sy = dy;
    sx = (sx * x_scale_q) >> 16;
    sy = (sy * y_scale_q) >> 16;
    if (sx >= 256 || sy >= 256) return 8'hFF;
    radius_sq = sx * sx + sy * sy;
    if (radius_sq >= 65536) return 8'hFF;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radius_sq) root = trial;
    end
    return root[7:0];
  endfunction

  function automatic void predict_transfer(logic cmd, logic [7:0] addr, logic [31:0] color,
                                           bit known, pixel_result_t known_result);
    pixel_result_t predicted;
    int unsigned w, h;
    if (cmd == rgpg_pkg::CMD_TABLE_WRITE) begin
      palette[addr]        = color;
      palette_loaded[addr] = 1'b1;
      table_writes++;
      return;
    end
    w = clamp_dimension(cfg_width_q);
    h = clamp_dimension(cfg_height_q);
    predicted.color = palette[gradient_index()];
    predicted.eor   = (raster_col == w - 1);
    predicted.eof   = predicted.eor && (raster_row == h - 1);
    if (predicted.eor) begin
      raster_col = '0;
      raster_row = predicted.eof ? 12'd0 : raster_row + 12'd1;
    end else begin
      raster_col = raster_col + 12'd1;
    end
    expected_pixels.push_back(known ? known_result : predicted);
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, what);
  endfunction

  function automatic void add_step(step_kind_t kind, logic [7:0] addr, logic [31:0] data,
                                   logic eor = 1'b0, logic eof = 1'b0);
    directed_step_t s;
    s.kind = kind;
    s.addr = addr;
    s.data = data;
    s.eor  = eor;
    s.eof  = eof;
    directed_steps.push_back(s);
  endfunction

  function automatic logic [31:0] pick_dimension();
    logic [31:0] dim;
    case ($urandom_range(0, 9))
      0:             dim = $urandom_range(0, 1);
      1, 2, 3, 4, 5: dim = $urandom_range(2, 16);
      6, 7:          dim = $urandom_range(17, 300);
      8:             dim = $urandom_range(301, 8191);
      default:       dim = $urandom_range(0, 1) ? MAX_DIMENSION : 8191;
    endcase
    if ($urandom_range(0, 3) == 0) dim |= $urandom() & 32'hFFFF_E000;
    return dim;
  endfunction

  function automatic logic [31:0] pick_scale(int unsigned dim);
    logic [31:0] s;
    int unsigned tuned;
    tuned = RIM_SCALE_NUM / dim;
    case ($urandom_range(0, 7))
      0:       s = 0;
      1:       s = 24'hFF_FFFF;
      2:       s = $urandom_range(0, 24'hFF_FFFF);
      3:       s = $urandom_range(0, 32'h3_FFFF);
      default: s = tuned - tuned / 4 + $urandom_range(0, tuned / 2);
    endcase
    if ($urandom_range(0, 3) == 0) s |= $urandom() & 32'hFF00_0000;
    return s;
  endfunction

  task automatic transfer_item(logic cmd, logic [7:0] addr, logic [31:0] color,
                               bit known, pixel_result_t known_result);
    in_push        <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= addr;
    in_entry_color <= color;
    do @(posedge clk); while (in_full !== 1'b0);
    predict_transfer(cmd, addr, color, known, known_result);
  endtask

  // Load the entry the next pixel reads if it was never written
  task automatic push_pixel(bit known, pixel_result_t known_result);
    logic [7:0] addr;
    addr = gradient_index();
    if (!palette_loaded[addr]) begin
      transfer_item(rgpg_pkg::CMD_TABLE_WRITE, addr, $urandom(), 1'b0, '0);
    end
    transfer_item(rgpg_pkg::CMD_PIXEL, 8'($urandom_range(0, 255)), $urandom(),
                  known, known_result);
  endtask

  task automatic settle_block();
    in_push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [rgpg_pkg::CFG_INDEX_W-1:0] idx,
                                logic [rgpg_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      rgpg_pkg::REG_IMAGE_WIDTH: begin
        cfg_width_q = value[rgpg_pkg::DIM_CFG_W-1:0];
        raster_row  = '0;
        raster_col  = '0;
      end
      rgpg_pkg::REG_IMAGE_HEIGHT: begin
        cfg_height_q = value[rgpg_pkg::DIM_CFG_W-1:0];
        raster_row   = '0;
        raster_col   = '0;
      end
      rgpg_pkg::REG_X_SCALE: x_scale_q = value[rgpg_pkg::SCALE_W-1:0];
      rgpg_pkg::REG_Y_SCALE: y_scale_q = value[rgpg_pkg::SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic idle_sender();
    int unsigned gap;
    if (burst_left > 1) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
  endtask

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    bit            pop_next;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected pixel color=%08h eor=%0b eof=%0b",
                               out_pixel_color, out_end_of_row, out_end_of_frame));
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_color !== want.color || out_end_of_row !== want.eor ||
            out_end_of_frame !== want.eof) begin
          note_failure($sformatf("pixel %0d: expected color=%08h eor=%0b eof=%0b, got %08h %0b %0b",
                                 pixels_seen, want.color, want.eor, want.eof,
                                 out_pixel_color, out_end_of_row, out_end_of_frame));
        end
        pixels_seen++;
        if (out_end_of_row === 1'b1) rows_seen++;
        if (out_end_of_frame === 1'b1) frames_seen++;
      end
    end
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(40, 300);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_STREAM: pop_next = 1'b1;
      RX_COIN:   pop_next = 1'($urandom_range(0, 1));
      RX_LONG_HOLD: begin
        if (rx_hold != 0) begin
          pop_next = 1'b0;
          rx_hold--;
        end else begin
          pop_next = 1'b1;
          if ($urandom_range(0, 5) == 0) rx_hold = $urandom_range(1, 24);
        end
      end
      default: begin
        pop_next = (rx_tick % 3 == 0);
        rx_tick++;
      end
    endcase
    out_pop <= pop_next;
  end

  initial begin : stimulus
    directed_step_t step;
    pixel_result_t  known;
    int unsigned    random_items;
    int unsigned    phase_len;
    bit             scales_only;
    random_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: corner pixel reads the last entry
    add_step(STEP_TABLE, 8'hFF, 32'hFFFF_FFFF);
    add_step(STEP_TABLE, 8'h00, 32'h0000_0000);
    add_step(STEP_PIXEL_KNOWN, '0, 32'hFFFF_FFFF);
    // Zero scales: every pixel reads entry zero, raster keeps its place
    add_step(STEP_CONFIG, rgpg_pkg::REG_X_SCALE, 32'h0);
    add_step(STEP_CONFIG, rgpg_pkg::REG_Y_SCALE, 32'h0);
    add_step(STEP_PIXEL_KNOWN, '0, 32'h0000_0000);
    // Dimensions below range clamp to 2x2; walk a whole frame and wrap
    add_step(STEP_CONFIG, rgpg_pkg::REG_IMAGE_WIDTH, 32'd0);
    add_step(STEP_CONFIG, rgpg_pkg::REG_IMAGE_HEIGHT, 32'd1);
    add_step(STEP_TABLE, 8'h00, 32'h5A5A_A5A5);
    add_step(STEP_PIXEL_KNOWN, '0, 32'h5A5A_A5A5, 1'b0, 1'b0);
    add_step(STEP_PIXEL_KNOWN, '0, 32'h5A5A_A5A5, 1'b1, 1'b0);
    add_step(STEP_PIXEL_KNOWN, '0, 32'h5A5A_A5A5, 1'b0, 1'b0);
    add_step(STEP_PIXEL_KNOWN, '0, 32'h5A5A_A5A5, 1'b1, 1'b1);
    add_step(STEP_PIXEL_KNOWN, '0, 32'h5A5A_A5A5, 1'b0, 1'b0);
    // Full-scale registers saturate the index
    add_step(STEP_CONFIG, rgpg_pkg::REG_X_SCALE, 32'hFFFF_FFFF);
    add_step(STEP_CONFIG, rgpg_pkg::REG_Y_SCALE, 32'h00FF_FFFF);
    add_step(STEP_PIXEL_KNOWN, '0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_step(STEP_PIXEL_KNOWN, '0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // Width above range clamps to the maximum
    add_step(STEP_CONFIG, rgpg_pkg::REG_IMAGE_WIDTH, 32'hFFFF_FFFF);
    add_step(STEP_CONFIG, rgpg_pkg::REG_IMAGE_HEIGHT, 32'd2);
    add_step(STEP_PIXEL_KNOWN, '0, 32'hFFFF_FFFF);
    // Writes past the register list are dropped
    add_step(STEP_CONFIG, REG_UNUSED_FIRST, 32'h0000_0003);
    add_step(STEP_CONFIG, REG_UNUSED_LAST, 32'hFFFF_FFFF);
    add_step(STEP_PIXEL_KNOWN, '0, 32'hFFFF_FFFF);
    add_step(STEP_CONFIG, rgpg_pkg::REG_IMAGE_WIDTH, 32'd5);
    add_step(STEP_CONFIG, rgpg_pkg::REG_IMAGE_HEIGHT, 32'd3);
    add_step(STEP_CONFIG, rgpg_pkg::REG_X_SCALE, 32'h0001_0000);
    add_step(STEP_CONFIG, rgpg_pkg::REG_Y_SCALE, 32'h0001_8000);
    add_step(STEP_TABLE, 8'h01, 32'h0123_4567);
    add_step(STEP_TABLE, 8'h02, 32'h89AB_CDEF);
    repeat (6) add_step(STEP_PIXEL, '0, '0);

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      case (step.kind)
        STEP_CONFIG: begin
          settle_block();
          write_register(step.addr, step.data);
        end
        STEP_TABLE: transfer_item(rgpg_pkg::CMD_TABLE_WRITE, step.addr, step.data, 1'b0, '0);
        STEP_PIXEL: push_pixel(1'b0, '0);
        default: begin
          known.color = step.data;
          known.eor   = step.eor;
          known.eof   = step.eof;
          push_pixel(1'b1, known);
        end
      endcase
    end

    while (random_items < RANDOM_ITEMS) begin
      settle_block();
      scales_only = ($urandom_range(0, 4) == 0);
      if (!scales_only) begin
        write_register(rgpg_pkg::REG_IMAGE_WIDTH, pick_dimension());
        write_register(rgpg_pkg::REG_IMAGE_HEIGHT, pick_dimension());
      end
      write_register(rgpg_pkg::REG_X_SCALE, pick_scale(clamp_dimension(cfg_width_q)));
      write_register(rgpg_pkg::REG_Y_SCALE, pick_scale(clamp_dimension(cfg_height_q)));
      if ($urandom_range(0, 5) == 0) begin
        write_register(8'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom());
      end
      settings_applied++;
      phase_len = $urandom_range(60, 200);
      if (phase_len > RANDOM_ITEMS - random_items) phase_len = RANDOM_ITEMS - random_items;
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          transfer_item(rgpg_pkg::CMD_TABLE_WRITE, 8'($urandom_range(0, 255)), $urandom(),
                        1'b0, '0);
        end else begin
          push_pixel(1'b0, '0);
        end
        random_items++;
        idle_sender();
      end
    end

    settle_block();
    $display("Checked %0d pixels (%0d row ends, %0d frame ends) after %0d table loads",
             pixels_seen, rows_seen, frames_seen, table_writes);
    $display("Random register settings: %0d, mismatches: %0d", settings_applied, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
